// File: hdl/rpc_pkg.sv
// Shared types, constants and helper functions of the reflow profile controller.
package rpc_pkg;

	// Register file geometry and APB data width.
	localparam int DATA_W   = 32;
	localparam int NUM_REGS = 6;
	localparam int IDX_W    = $clog2(NUM_REGS);
	localparam int ADDR_W   = IDX_W + 2;

	// Profile geometry: points in use, the last one of them, and field widths.
	localparam int NUM_POINTS = 6;
	localparam int LAST_PT    = NUM_POINTS - 1;
	localparam int SEC_W      = 16;
	localparam int TEMP_W     = 16;
	localparam int CMD_W      = 2;
	localparam int MTEMP_W    = 10;

	// Timing constants.
	localparam int TICK_MS      = 50;
	localparam int MS_PER_S     = 1000;
	localparam int TICKS_W      = 16;
	localparam int T_W          = $clog2(TICK_MS * (2 ** TICKS_W));
	localparam int X_W          = $clog2(MS_PER_S * (2 ** SEC_W));
	localparam int CMP_W        = (T_W > X_W) ? T_W : X_W;
	localparam int PROD_W       = T_W + TEMP_W;

	// Buzzer and report pacing.
	localparam int BUZZ_TICKS   = 60;
	localparam int BUZZ_PERIOD  = 10;
	localparam int BUZZ_W       = $clog2(BUZZ_TICKS + 1);
	localparam int REPORT_TICKS = 10;
	localparam int RPH_W        = $clog2(REPORT_TICKS);

	// The profile points as one packed word per register.
	typedef logic [NUM_REGS-1:0][DATA_W-1:0] point_arr_t;

	localparam point_arr_t POINT_RESET = {
		32'd1310876,
		32'd12779760,
		32'd12124380,
		32'd8519830,
		32'd7864380,
		32'd1310720
	};

	// Input commands.
	typedef enum logic [CMD_W-1:0] {
		CMD_TICK  = 2'd0,
		CMD_START = 2'd1,
		CMD_ABORT = 2'd2,
		CMD_RSVD  = 2'd3
	} cmd_t;

	// Sequencer states of the top level.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_SEARCH,
		ST_MUL,
		ST_DIV,
		ST_FINAL,
		ST_OUT
	} state_t;

	// Time field of a profile point, in seconds.
	function automatic logic [SEC_W-1:0] pt_sec(input logic [DATA_W-1:0] p);
		return p[SEC_W-1:0];
	endfunction

	// Temperature field of a profile point, in degrees.
	function automatic logic [TEMP_W-1:0] pt_temp(input logic [DATA_W-1:0] p);
		return p[DATA_W-1:SEC_W];
	endfunction

	// Converts seconds to milliseconds.
	function automatic logic [X_W-1:0] ms_of_sec(input logic [SEC_W-1:0] s);
		return X_W'(s) * X_W'(MS_PER_S);
	endfunction

	// Converts elapsed ticks to milliseconds.
	function automatic logic [T_W-1:0] ms_of_ticks(input logic [TICKS_W-1:0] e);
		return T_W'(e) * T_W'(TICK_MS);
	endfunction

	// True when the remaining buzzer count lies on a toggle boundary.
	function automatic logic buzz_toggle(input logic [BUZZ_W-1:0] r);
		logic hit;
		hit = 1'b0;
		for (int k = 1; k <= BUZZ_TICKS / BUZZ_PERIOD; k++) begin
			if (r == BUZZ_W'(k * BUZZ_PERIOD)) hit = 1'b1;
		end
		return hit;
	endfunction

endpackage

// File: hdl/rpc_regs.sv
// APB register file that holds the profile points.
module rpc_regs (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [rpc_pkg::ADDR_W-1:0]         paddr,
	input  logic [rpc_pkg::DATA_W-1:0]         pwdata,
	output logic [rpc_pkg::DATA_W-1:0]         prdata,
	output logic                               pready,
	output rpc_pkg::point_arr_t                points
);

	logic [rpc_pkg::IDX_W-1:0] idx;
	logic                      in_range;
	rpc_pkg::point_arr_t       points_q;

	assign idx      = paddr[rpc_pkg::ADDR_W-1:2];
	assign in_range = (idx < rpc_pkg::IDX_W'(rpc_pkg::NUM_REGS));
	assign pready   = 1'b1;
	assign points   = points_q;

	// Register writes complete in the access phase.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			points_q <= rpc_pkg::POINT_RESET;
		end else if (psel && penable && pwrite && in_range) begin
			points_q[idx] <= pwdata;
		end
	end

	// Read data; addresses past the list read as zero.
	always_comb begin
		prdata = '0;
		if (in_range) prdata = points_q[idx];
	end

endmodule

// File: hdl/rpc_mul.sv
// Bit-serial shift-add multiplier for the interpolation numerator.
module rpc_mul (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [rpc_pkg::TEMP_W-1:0]    mcand,
	input  logic [rpc_pkg::T_W-1:0]       mplier,
	output logic                          done,
	output logic [rpc_pkg::PROD_W-1:0]    product
);

	localparam int CNT_W = $clog2(rpc_pkg::T_W);

	logic                          busy_q;
	logic                          done_q;
	logic [CNT_W-1:0]              cnt_q;
	logic [rpc_pkg::TEMP_W-1:0]    mcand_q;
	logic [rpc_pkg::PROD_W-1:0]    p_q;
	logic [rpc_pkg::TEMP_W:0]      sum;

	assign done    = done_q;
	assign product = p_q;

	// Upper half plus the multiplicand when the current multiplier bit is set.
	always_comb begin
		sum = {1'b0, p_q[rpc_pkg::PROD_W-1:rpc_pkg::T_W]};
		if (p_q[0]) sum = sum + {1'b0, mcand_q};
	end

	// Step control: one multiplier bit per cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= !start && busy_q && (cnt_q == CNT_W'(rpc_pkg::T_W - 1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(rpc_pkg::T_W - 1)) busy_q <= 1'b0;
			end
		end
	end

	// Product shift register; the multiplier starts in the low bits.
	always_ff @(posedge clk) begin
		if (start) begin
			mcand_q <= mcand;
			p_q     <= {{rpc_pkg::TEMP_W{1'b0}}, mplier};
		end else if (busy_q) begin
			p_q <= {sum, p_q[rpc_pkg::T_W-1:1]};
		end
	end

endmodule

// File: hdl/rpc_div.sv
// Bit-serial restoring divider that yields the interpolation step.
module rpc_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [rpc_pkg::PROD_W-1:0]    num,
	input  logic [rpc_pkg::X_W-1:0]       den,
	output logic                          done,
	output logic [rpc_pkg::TEMP_W-1:0]    quot,
	output logic                          rem_nz
);

	localparam int QUO_W = rpc_pkg::TEMP_W;
	localparam int CNT_W = $clog2(QUO_W);

	logic                       busy_q;
	logic                       done_q;
	logic [CNT_W-1:0]           cnt_q;
	logic [rpc_pkg::X_W-1:0]    den_q;
	logic [rpc_pkg::X_W-1:0]    rem_q;
	logic [QUO_W-1:0]           sh_q;
	logic [rpc_pkg::X_W:0]      trial;
	logic [rpc_pkg::X_W:0]      diff;
	logic                       ge;

	assign done   = done_q;
	assign quot   = sh_q;
	assign rem_nz = (rem_q != '0);

	// One trial subtraction per cycle.
	always_comb begin
		trial = {rem_q, sh_q[QUO_W-1]};
		diff  = trial - {1'b0, den_q};
		ge    = (trial >= {1'b0, den_q});
	end

	// Step control: one quotient bit per cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= !start && busy_q && (cnt_q == CNT_W'(QUO_W - 1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(QUO_W - 1)) busy_q <= 1'b0;
			end
		end
	end

	// The quotient is known to fit in QUO_W bits, so the upper part of the
	// numerator starts out below the divisor.
	always_ff @(posedge clk) begin
		if (start) begin
			den_q <= den;
			rem_q <= rpc_pkg::X_W'(num >> QUO_W);
			sh_q  <= num[QUO_W-1:0];
		end else if (busy_q) begin
			rem_q <= ge ? diff[rpc_pkg::X_W-1:0] : trial[rpc_pkg::X_W-1:0];
			sh_q  <= {sh_q[QUO_W-2:0], ge};
		end
	end

endmodule

// File: hdl/reflow_profile_controller_core.sv
// Sequence: start, abort, idle ticks and unused codes go from acceptance through EXEC and OUT;
// a running tick goes through EXEC, a segment search if needed, FINAL and OUT; an interpolated one
// adds a bit-serial multiply and divide (each ending on its done strobe) between search and FINAL.
// Throughput: one transaction at a time; the next is accepted once the result is registered.
// Reset (arst_n low, asynchronous): run stopped, counters and levels cleared, default profile.
// Profile registers lie on an APB port at byte address 4*i.
module reflow_profile_controller_core (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic [rpc_pkg::CMD_W-1:0]          command,
	input  logic [rpc_pkg::MTEMP_W-1:0]        measured_temp,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic                               heater_on,
	output logic [rpc_pkg::TEMP_W-1:0]         target_temp,
	output logic                               run_complete,
	output logic                               report_due,
	output logic                               buzzer_on,
	output logic                               running,
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [rpc_pkg::ADDR_W-1:0]         paddr,
	input  logic [rpc_pkg::DATA_W-1:0]         pwdata,
	output logic [rpc_pkg::DATA_W-1:0]         prdata,
	output logic                               pready
);

	rpc_pkg::point_arr_t              points;
	rpc_pkg::state_t                  state_q;
	rpc_pkg::state_t                  state_d;

	// Controller state.
	logic                             run_q;
	logic [rpc_pkg::TICKS_W-1:0]      elapsed_q;
	logic [rpc_pkg::RPH_W-1:0]        rphase_q;
	logic [rpc_pkg::BUZZ_W-1:0]       buzz_rem_q;
	logic                             buzz_lvl_q;
	logic                             heat_q;
	logic                             out_valid_q;

	// Per-transaction working registers.
	rpc_pkg::cmd_t                    cmd_q;
	logic [rpc_pkg::MTEMP_W-1:0]      temp_q;
	logic [rpc_pkg::T_W-1:0]          t_q;
	logic [rpc_pkg::IDX_W-1:0]        idx_q;
	logic [rpc_pkg::X_W-1:0]          prev_x_q;
	logic [rpc_pkg::TEMP_W-1:0]       prev_y_q;
	logic [rpc_pkg::TEMP_W-1:0]       base_q;
	logic                             neg_q;
	logic [rpc_pkg::X_W-1:0]          den_q;
	logic [rpc_pkg::TEMP_W-1:0]       tgt_q;
	logic                             done_q;
	logic                             complete_q;
	logic                             report_q;

	// Output register.
	logic                             heater_on_q;
	logic [rpc_pkg::TEMP_W-1:0]       target_temp_q;
	logic                             run_complete_q;
	logic                             report_due_q;
	logic                             buzzer_on_q;
	logic                             running_q;

	// Datapath decisions.
	logic [rpc_pkg::X_W-1:0]          x_first;
	logic [rpc_pkg::X_W-1:0]          x_last;
	logic [rpc_pkg::X_W-1:0]          x_cur;
	logic [rpc_pkg::TEMP_W-1:0]       y_cur;
	logic                             le_first;
	logic                             ge_last;
	logic                             seg_hit;
	logic                             last_idx;
	logic [rpc_pkg::CMP_W-1:0]        dt_full;
	logic [rpc_pkg::TEMP_W:0]         y_up;
	logic [rpc_pkg::TEMP_W:0]         y_down;
	logic [rpc_pkg::TEMP_W-1:0]       y_mag;
	logic [rpc_pkg::TEMP_W:0]         tgt_calc;
	logic                             tick_run;
	logic                             out_free;
	logic [rpc_pkg::RPH_W-1:0]        rp_inc;
	logic                             rp_wrap;
	logic [rpc_pkg::BUZZ_W-1:0]       buzz_dec;

	// Sequencer outputs and unit handshakes.
	logic                             mul_start;
	logic                             mul_done;
	logic [rpc_pkg::PROD_W-1:0]       product;
	logic                             div_start;
	logic                             div_done;
	logic [rpc_pkg::TEMP_W-1:0]       quot;
	logic                             rem_nz;
	logic                             out_load;

	rpc_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.points  (points)
	);

	rpc_mul u_mul (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (mul_start),
		.mcand   (y_mag),
		.mplier  (dt_full[rpc_pkg::T_W-1:0]),
		.done    (mul_done),
		.product (product)
	);

	rpc_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.num     (product),
		.den     (den_q),
		.done    (div_done),
		.quot    (quot),
		.rem_nz  (rem_nz)
	);

	// Segment bounds and the interpolation operands for the current search index.
	always_comb begin
		x_first  = rpc_pkg::ms_of_sec(rpc_pkg::pt_sec(points[0]));
		x_last   = rpc_pkg::ms_of_sec(rpc_pkg::pt_sec(points[rpc_pkg::LAST_PT]));
		x_cur    = rpc_pkg::ms_of_sec(rpc_pkg::pt_sec(points[idx_q]));
		y_cur    = rpc_pkg::pt_temp(points[idx_q]);
		le_first = (rpc_pkg::CMP_W'(t_q) <= rpc_pkg::CMP_W'(x_first));
		ge_last  = (rpc_pkg::CMP_W'(t_q) >= rpc_pkg::CMP_W'(x_last));
		seg_hit  = (rpc_pkg::CMP_W'(t_q) <= rpc_pkg::CMP_W'(x_cur)) &&
			(rpc_pkg::CMP_W'(t_q) > rpc_pkg::CMP_W'(prev_x_q));
		last_idx = (idx_q == rpc_pkg::IDX_W'(rpc_pkg::LAST_PT));
		dt_full  = rpc_pkg::CMP_W'(t_q) - rpc_pkg::CMP_W'(prev_x_q);
		y_up     = {1'b0, y_cur} - {1'b0, prev_y_q};
		y_down   = {1'b0, prev_y_q} - {1'b0, y_cur};
		y_mag    = y_up[rpc_pkg::TEMP_W] ? y_down[rpc_pkg::TEMP_W-1:0] :
			y_up[rpc_pkg::TEMP_W-1:0];
	end

	// Floor division: a negative slope rounds away from zero when inexact.
	always_comb begin
		if (neg_q) begin
			tgt_calc = {1'b0, base_q} - {1'b0, quot} -
				{{rpc_pkg::TEMP_W{1'b0}}, rem_nz};
		end else begin
			tgt_calc = {1'b0, base_q} + {1'b0, quot};
		end
	end

	// Command decode, output handshake and counter arithmetic shared by the update blocks.
	always_comb begin
		tick_run = (cmd_q == rpc_pkg::CMD_TICK) && run_q;
		out_free = !out_valid_q || !out_stall;
		rp_inc   = rphase_q + 1'b1;
		rp_wrap  = (rp_inc >= rpc_pkg::RPH_W'(rpc_pkg::REPORT_TICKS));
		buzz_dec = buzz_rem_q - 1'b1;
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			rpc_pkg::ST_IDLE: begin
				if (in_valid) state_d = rpc_pkg::ST_EXEC;
			end
			rpc_pkg::ST_EXEC: begin
				if (tick_run && !le_first && !ge_last) state_d = rpc_pkg::ST_SEARCH;
				else if (tick_run) state_d = rpc_pkg::ST_FINAL;
				else state_d = rpc_pkg::ST_OUT;
			end
			rpc_pkg::ST_SEARCH: begin
				if (seg_hit) state_d = rpc_pkg::ST_MUL;
				else if (last_idx) state_d = rpc_pkg::ST_FINAL;
			end
			rpc_pkg::ST_MUL: begin
				if (mul_done) state_d = rpc_pkg::ST_DIV;
			end
			rpc_pkg::ST_DIV: begin
				if (div_done) state_d = rpc_pkg::ST_FINAL;
			end
			rpc_pkg::ST_FINAL: begin
				state_d = rpc_pkg::ST_OUT;
			end
			rpc_pkg::ST_OUT: begin
				if (out_free) state_d = rpc_pkg::ST_IDLE;
			end
			default: state_d = rpc_pkg::ST_IDLE;
		endcase
	end

	// Sequencer outputs.
	always_comb begin
		in_stall  = (state_q != rpc_pkg::ST_IDLE);
		mul_start = (state_q == rpc_pkg::ST_SEARCH) && seg_hit;
		div_start = (state_q == rpc_pkg::ST_MUL) && mul_done;
		out_load  = (state_q == rpc_pkg::ST_OUT) && out_free;
	end

	// State register and controller state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= rpc_pkg::ST_IDLE;
			run_q       <= 1'b0;
			elapsed_q   <= '0;
			rphase_q    <= '0;
			buzz_rem_q  <= '0;
			buzz_lvl_q  <= 1'b0;
			heat_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (out_load) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;

			if (state_q == rpc_pkg::ST_EXEC) begin
				unique case (cmd_q)
					rpc_pkg::CMD_START, rpc_pkg::CMD_ABORT: begin
						run_q      <= (cmd_q == rpc_pkg::CMD_START);
						elapsed_q  <= '0;
						rphase_q   <= '0;
						buzz_rem_q <= '0;
						buzz_lvl_q <= 1'b0;
						heat_q     <= 1'b0;
					end
					rpc_pkg::CMD_TICK: begin
						// Idle ticks count down the buzzer.
						if (!run_q && (buzz_rem_q != '0)) begin
							buzz_rem_q <= buzz_dec;
							if (buzz_dec == '0) buzz_lvl_q <= 1'b0;
							else if (rpc_pkg::buzz_toggle(buzz_dec)) buzz_lvl_q <= !buzz_lvl_q;
						end
					end
					rpc_pkg::CMD_RSVD: begin
					end
					default: begin
					end
				endcase
			end

			// Close a running tick: heater decision, counters, and run end.
			if (state_q == rpc_pkg::ST_FINAL) begin
				if (done_q) begin
					heat_q     <= 1'b0;
					run_q      <= 1'b0;
					elapsed_q  <= '0;
					rphase_q   <= '0;
					buzz_rem_q <= rpc_pkg::BUZZ_W'(rpc_pkg::BUZZ_TICKS);
					buzz_lvl_q <= 1'b1;
				end else begin
					heat_q   <= (rpc_pkg::TEMP_W'(temp_q) < tgt_q);
					rphase_q <= rp_wrap ? '0 : rp_inc;
					if (elapsed_q != '1) elapsed_q <= elapsed_q + 1'b1;
				end
			end
		end
	end

	// Working registers of the transaction in flight.
	always_ff @(posedge clk) begin
		unique case (state_q)
			rpc_pkg::ST_IDLE: begin
				cmd_q  <= rpc_pkg::cmd_t'(command);
				temp_q <= measured_temp;
				t_q    <= rpc_pkg::ms_of_ticks(elapsed_q);
			end
			rpc_pkg::ST_EXEC: begin
				complete_q <= 1'b0;
				report_q   <= 1'b0;
				prev_x_q   <= x_first;
				prev_y_q   <= rpc_pkg::pt_temp(points[0]);
				idx_q      <= rpc_pkg::IDX_W'(1);
				tgt_q      <= (tick_run && le_first) ? rpc_pkg::pt_temp(points[0]) : '0;
				done_q     <= tick_run && !le_first && ge_last;
			end
			rpc_pkg::ST_SEARCH: begin
				// Walk the segments upward so the lowest matching one wins.
				if (seg_hit) begin
					base_q <= prev_y_q;
					neg_q  <= y_up[rpc_pkg::TEMP_W];
					den_q  <= x_cur - prev_x_q;
				end else begin
					prev_x_q <= x_cur;
					prev_y_q <= y_cur;
					idx_q    <= idx_q + 1'b1;
				end
			end
			rpc_pkg::ST_MUL: begin
			end
			rpc_pkg::ST_DIV: begin
				if (div_done) tgt_q <= tgt_calc[rpc_pkg::TEMP_W-1:0];
			end
			rpc_pkg::ST_FINAL: begin
				complete_q <= done_q;
				report_q   <= rp_wrap;
			end
			rpc_pkg::ST_OUT: begin
			end
			default: begin
			end
		endcase
	end

	// Output register, loaded once the previous result has been taken.
	always_ff @(posedge clk) begin
		if (out_load) begin
			heater_on_q    <= heat_q;
			target_temp_q  <= tgt_q;
			run_complete_q <= complete_q;
			report_due_q   <= report_q;
			buzzer_on_q    <= buzz_lvl_q;
			running_q      <= run_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign heater_on    = heater_on_q;
	assign target_temp  = target_temp_q;
	assign run_complete = run_complete_q;
	assign report_due   = report_due_q;
	assign buzzer_on    = buzzer_on_q;
	assign running      = running_q;

`ifndef SYNTHESIS
	// A completing tick stops the run, cuts the heater and sounds the buzzer.
	a_complete_ends_run: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && run_complete |-> !running && !heater_on && buzzer_on &&
		(target_temp == '0))
		else $error("run completion result is inconsistent");

	// The report phase stays within one report period.
	a_rphase_range: assert property (@(posedge clk) disable iff (!arst_n)
		rphase_q < rpc_pkg::RPH_W'(rpc_pkg::REPORT_TICKS))
		else $error("report phase out of range");

	// The buzzer only sounds while its countdown runs.
	a_buzz_count: assert property (@(posedge clk) disable iff (!arst_n)
		buzz_lvl_q |-> (buzz_rem_q != '0))
		else $error("buzzer on with no countdown left");

	// The divider is only started from a finished multiply.
	a_div_after_mul: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> (state_q == rpc_pkg::ST_MUL) && mul_done)
		else $error("divider started without a product");
`endif

endmodule
